// File: rtl/stcf_pkg.sv
// Shared types and constants for the shadow texture coordinate and fade unit.
package stcf_pkg;

	localparam int ONE_Q12 = 4096;
	localparam int Y_DROP_Q12 = 205;
	localparam int DIV_STEPS = 20;
	localparam int SUM_W = 56;
	localparam int DIV_W = 64;

	typedef enum logic [2:0] {
		REG_NIGHT_MODE = 3'd0,
		REG_ROW_X      = 3'd1,
		REG_ROW_Y      = 3'd2,
		REG_ROW_Z      = 3'd3,
		REG_ROW_OFFSET = 3'd4,
		REG_VIEW_X     = 3'd5,
		REG_VIEW_Z     = 3'd6
	} stcf_reg_t;

	typedef struct packed {
		logic night;
		logic fault;
		logic neg_u;
		logic neg_v;
		logic clamp_u;
		logic clamp_v;
		logic eom;
	} stcf_side_t;

	typedef struct packed {
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
		logic [7:0]         fade_level;
		logic               in_square;
		logic               divide_fault;
		logic               mesh_done;
	} stcf_res_t;

endpackage

// File: rtl/stcf_front.sv
// Front pipeline: input offsets, matrix products, row sums and divider set-up.
module stcf_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [31:0]         pos_x,
	input  logic signed [31:0]         pos_y,
	input  logic signed [31:0]         pos_z,
	input  logic                       end_of_mesh,
	input  logic                       night_mode,
	input  logic [59:0]                row_x,
	input  logic [59:0]                row_y,
	input  logic [59:0]                row_z,
	input  logic [59:0]                row_off,
	input  logic [63:0]                view_x,
	input  logic [63:0]                view_z,
	output logic                       valid_s4,
	output stcf_pkg::stcf_side_t       side_s4,
	output logic [stcf_pkg::DIV_W-1:0] rem_u_s4,
	output logic [stcf_pkg::DIV_W-1:0] dsh_u_s4,
	output logic [stcf_pkg::DIV_W-1:0] rem_v_s4,
	output logic [stcf_pkg::DIV_W-1:0] dsh_v_s4
);
	import stcf_pkg::*;

	logic signed [19:0] cx[3];
	logic signed [19:0] cy[3];
	logic signed [19:0] cz[3];
	logic signed [19:0] co[3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cx[k] = row_x[20*k +: 20];
			cy[k] = row_y[20*k +: 20];
			cz[k] = row_z[20*k +: 20];
			co[k] = row_off[20*k +: 20];
		end
	end

	// Stage 1: widen positions, drop y and take the view offsets and extents.
	logic v_s1, night_s1, eom_s1;
	logic signed [32:0] x_s1, yd_s1, z_s1, nx_s1, nz_s1, ex_s1, ez_s1;
	logic signed [32:0] xmin, xmax, zmin, zmax;

	assign xmin = 33'(signed'(view_x[31:0]));
	assign xmax = 33'(signed'(view_x[63:32]));
	assign zmin = 33'(signed'(view_z[31:0]));
	assign zmax = 33'(signed'(view_z[63:32]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			night_s1 <= night_mode;
			eom_s1 <= end_of_mesh;
			x_s1 <= 33'(pos_x);
			yd_s1 <= 33'(pos_y) - 33'(Y_DROP_Q12);
			z_s1 <= 33'(pos_z);
			nx_s1 <= 33'(pos_x) - xmin;
			nz_s1 <= 33'(pos_z) - zmin;
			ex_s1 <= xmax - xmin;
			ez_s1 <= zmax - zmin;
		end
	end

	// Stage 2: the nine matrix products and the aligned constant terms.
	logic v_s2, night_s2, eom_s2;
	logic signed [52:0] px_s2[3], py_s2[3], pz_s2[3];
	logic signed [31:0] po_s2[3];
	logic signed [32:0] nx_s2, nz_s2, ex_s2, ez_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				px_s2[k] <= 53'(cx[k]) * 53'(x_s1);
				py_s2[k] <= 53'(cy[k]) * 53'(yd_s1);
				pz_s2[k] <= 53'(cz[k]) * 53'(z_s1);
				po_s2[k] <= {co[k], 12'b0};
			end
			night_s2 <= night_s1;
			eom_s2 <= eom_s1;
			nx_s2 <= nx_s1;
			nz_s2 <= nz_s1;
			ex_s2 <= ex_s1;
			ez_s2 <= ez_s1;
		end
	end

	// Stage 3: row sums and mode selection of numerators and divisors.
	logic v_s3, night_s3, eom_s3;
	logic signed [SUM_W-1:0] nu_s3, du_s3, nv_s3, dv_s3;
	logic signed [SUM_W-1:0] sum[3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = SUM_W'(px_s2[k]) + SUM_W'(py_s2[k]) + SUM_W'(pz_s2[k])
				+ SUM_W'(po_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			night_s3 <= night_s2;
			eom_s3 <= eom_s2;
			nu_s3 <= night_s2 ? SUM_W'(nx_s2) : sum[0];
			nv_s3 <= night_s2 ? SUM_W'(nz_s2) : sum[1];
			du_s3 <= night_s2 ? SUM_W'(ex_s2) : sum[2];
			dv_s3 <= night_s2 ? SUM_W'(ez_s2) : sum[2];
		end
	end

	// Stage 4: magnitudes, signs, zero divisors and quotient overflow.
	logic [SUM_W-1:0] nmag_u, dmag_u, nmag_v, dmag_v;
	logic [DIV_W-1:0] dsh_u, dsh_v;

	assign nmag_u = nu_s3[SUM_W-1] ? SUM_W'(-nu_s3) : SUM_W'(nu_s3);
	assign nmag_v = nv_s3[SUM_W-1] ? SUM_W'(-nv_s3) : SUM_W'(nv_s3);
	assign dmag_u = du_s3[SUM_W-1] ? SUM_W'(-du_s3) : SUM_W'(du_s3);
	assign dmag_v = dv_s3[SUM_W-1] ? SUM_W'(-dv_s3) : SUM_W'(dv_s3);
	assign dsh_u = {dmag_u, 8'b0};
	assign dsh_v = {dmag_v, 8'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.night <= night_s3;
			side_s4.eom <= eom_s3;
			side_s4.fault <= (du_s3 == '0) || (dv_s3 == '0);
			side_s4.neg_u <= nu_s3[SUM_W-1] ^ du_s3[SUM_W-1];
			side_s4.neg_v <= nv_s3[SUM_W-1] ^ dv_s3[SUM_W-1];
			side_s4.clamp_u <= DIV_W'(nmag_u) >= dsh_u;
			side_s4.clamp_v <= DIV_W'(nmag_v) >= dsh_v;
			rem_u_s4 <= DIV_W'(nmag_u);
			rem_v_s4 <= DIV_W'(nmag_v);
			dsh_u_s4 <= dsh_u;
			dsh_v_s4 <= dsh_v;
		end
	end

endmodule

// File: rtl/stcf_divider.sv
// Pipelined restoring divider giving one quotient bit per stage.
module stcf_divider (
	input  logic                           clk,
	input  logic                           en,
	input  logic [stcf_pkg::DIV_W-1:0]     rem_in,
	input  logic [stcf_pkg::DIV_W-1:0]     div_in,
	output logic [stcf_pkg::DIV_STEPS-1:0] quot
);
	import stcf_pkg::*;

	logic [DIV_W-1:0]     rem_s[DIV_STEPS];
	logic [DIV_W-1:0]     div_s[DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s[DIV_STEPS];
	logic [DIV_W-1:0]     rem_nx[DIV_STEPS];
	logic [DIV_W-1:0]     div_pv[DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_nx[DIV_STEPS];
	logic [DIV_W:0]       dbl[DIV_STEPS];
	logic                 ge[DIV_STEPS];

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (k == 0) begin
				dbl[k] = {rem_in, 1'b0};
				div_pv[k] = div_in;
				quo_nx[k] = {{(DIV_STEPS-1){1'b0}}, 1'b0};
			end else begin
				dbl[k] = {rem_s[k-1], 1'b0};
				div_pv[k] = div_s[k-1];
				quo_nx[k] = quo_s[k-1];
			end
			ge[k] = dbl[k] >= {1'b0, div_pv[k]};
			rem_nx[k] = ge[k] ? DIV_W'(dbl[k] - {1'b0, div_pv[k]}) : DIV_W'(dbl[k]);
			quo_nx[k] = {quo_nx[k][DIV_STEPS-2:0], ge[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				rem_s[k] <= rem_nx[k];
				div_s[k] <= div_pv[k];
				quo_s[k] <= quo_nx[k];
			end
		end
	end

	assign quot = quo_s[DIV_STEPS-1];

endmodule

// File: rtl/stcf_back.sv
// Back pipeline: signed coordinates, inside test, fade level and saturation.
module stcf_back #(
	parameter int TEXEL_SIZE = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           valid_in,
	input  stcf_pkg::stcf_side_t           side_in,
	input  logic [stcf_pkg::DIV_STEPS-1:0] quot_u,
	input  logic [stcf_pkg::DIV_STEPS-1:0] quot_v,
	output logic                           valid_sb,
	output stcf_pkg::stcf_res_t            res_sb
);
	import stcf_pkg::*;

	localparam int OFF = (ONE_Q12 + TEXEL_SIZE / 2) / TEXEL_SIZE;

	logic [DIV_STEPS:0] qm_u, qm_v;
	logic signed [23:0] qs_u, qs_v, cu, cv;
	logic in_box;

	assign qm_u = side_in.clamp_u ? (DIV_STEPS+1)'(1) << DIV_STEPS : {1'b0, quot_u};
	assign qm_v = side_in.clamp_v ? (DIV_STEPS+1)'(1) << DIV_STEPS : {1'b0, quot_v};
	assign qs_u = side_in.neg_u ? -24'(qm_u) : 24'(qm_u);
	assign qs_v = side_in.neg_v ? -24'(qm_v) : 24'(qm_v);
	assign in_box = (qs_u >= 0) && (qs_u <= 24'(ONE_Q12)) && (qs_v >= 0)
		&& (qs_v <= 24'(ONE_Q12));
	assign cu = side_in.night ? 24'(ONE_Q12) - qs_u + 24'(OFF) : qs_u;
	assign cv = side_in.night ? qs_v + 24'(OFF) : qs_v;

	logic va_q;
	logic signed [23:0] u_sa, v_sa;
	logic in_sa, fault_sa, eom_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
		end else if (en) begin
			va_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_sa <= cu;
			v_sa <= cv;
			in_sa <= in_box && !side_in.fault;
			fault_sa <= side_in.fault;
			eom_sa <= side_in.eom;
		end
	end

	logic signed [25:0] du, dv, au, av, mn;
	logic [12:0] m;
	logic [20:0] scaled;
	logic [15:0] sat_u, sat_v;

	always_comb begin
		du = 26'(u_sa) * 26'sd2 - 26'(ONE_Q12);
		dv = 26'(v_sa) * 26'sd2 - 26'(ONE_Q12);
		if (du < 0) begin
			du = -du;
		end
		if (dv < 0) begin
			dv = -dv;
		end
		au = 26'(ONE_Q12) - du;
		av = 26'(ONE_Q12) - dv;
		mn = (au <= av) ? au : av;
		if (mn < 0) begin
			m = '0;
		end else if (mn > 26'(ONE_Q12)) begin
			m = 13'(ONE_Q12);
		end else begin
			m = mn[12:0];
		end
		scaled = {m, 8'b0} - 21'(m);
		if (u_sa > 24'sd32767) begin
			sat_u = 16'h7fff;
		end else if (u_sa < -24'sd32768) begin
			sat_u = 16'h8000;
		end else begin
			sat_u = u_sa[15:0];
		end
		if (v_sa > 24'sd32767) begin
			sat_v = 16'h7fff;
		end else if (v_sa < -24'sd32768) begin
			sat_v = 16'h8000;
		end else begin
			sat_v = v_sa[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sb <= 1'b0;
		end else if (en) begin
			valid_sb <= va_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sb.tex_u <= fault_sa ? '0 : sat_u;
			res_sb.tex_v <= fault_sa ? '0 : sat_v;
			res_sb.fade_level <= in_sa ? scaled[19:12] : 8'd0;
			res_sb.in_square <= in_sa;
			res_sb.divide_fault <= fault_sa;
			res_sb.mesh_done <= eom_sa;
		end
	end

endmodule

// File: rtl/shadow_texcoord_and_fade_unit.sv
// Top level of the shadow texture coordinate and fade unit.
// The unit takes one vertex per clock cycle unless in_stall is high. Each beat passes
// through four set-up stages, twenty divider stages that each resolve one quotient
// bit, two finishing stages and the output register. A one-entry output buffer lets
// the pipeline take a new beat while a finished result waits. Configuration must be
// written only while no vertex is in flight.
module shadow_texcoord_and_fade_unit #(
	parameter int TEXEL_SIZE = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic               end_of_mesh,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] tex_u,
	output logic signed [15:0] tex_v,
	output logic [7:0]         fade_level,
	output logic               in_square,
	output logic               divide_fault,
	output logic               mesh_done
);
	import stcf_pkg::*;

	logic        night_q;
	logic [59:0] row_x_q, row_y_q, row_z_q, row_off_q;
	logic [63:0] view_x_q, view_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			night_q <= 1'b0;
			row_x_q <= '0;
			row_y_q <= '0;
			row_z_q <= '0;
			row_off_q <= '0;
			view_x_q <= '0;
			view_z_q <= '0;
		end else if (cfg_we) begin
			case (stcf_reg_t'(cfg_index))
				REG_NIGHT_MODE: night_q <= cfg_data[0];
				REG_ROW_X: row_x_q <= cfg_data[59:0];
				REG_ROW_Y: row_y_q <= cfg_data[59:0];
				REG_ROW_Z: row_z_q <= cfg_data[59:0];
				REG_ROW_OFFSET: row_off_q <= cfg_data[59:0];
				REG_VIEW_X: view_x_q <= cfg_data;
				REG_VIEW_Z: view_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_v_q, out_valid_q;
	stcf_res_t skid_q, out_q;

	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	logic             v_s4;
	stcf_side_t       side_s4;
	logic [DIV_W-1:0] rem_u_s4, dsh_u_s4, rem_v_s4, dsh_v_s4;

	stcf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.end_of_mesh (end_of_mesh),
		.night_mode  (night_q),
		.row_x       (row_x_q),
		.row_y       (row_y_q),
		.row_z       (row_z_q),
		.row_off     (row_off_q),
		.view_x      (view_x_q),
		.view_z      (view_z_q),
		.valid_s4    (v_s4),
		.side_s4     (side_s4),
		.rem_u_s4    (rem_u_s4),
		.dsh_u_s4    (dsh_u_s4),
		.rem_v_s4    (rem_v_s4),
		.dsh_v_s4    (dsh_v_s4)
	);

	logic [DIV_STEPS-1:0] quot_u, quot_v;

	stcf_divider u_div_u (
		.clk    (clk),
		.en     (en),
		.rem_in (rem_u_s4),
		.div_in (dsh_u_s4),
		.quot   (quot_u)
	);

	stcf_divider u_div_v (
		.clk    (clk),
		.en     (en),
		.rem_in (rem_v_s4),
		.div_in (dsh_v_s4),
		.quot   (quot_v)
	);

	logic       dv_s[DIV_STEPS];
	stcf_side_t dside_s[DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				dv_s[k] <= 1'b0;
			end
		end else if (en) begin
			dv_s[0] <= v_s4;
			for (int k = 1; k < DIV_STEPS; k++) begin
				dv_s[k] <= dv_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_s[0] <= side_s4;
			for (int k = 1; k < DIV_STEPS; k++) begin
				dside_s[k] <= dside_s[k-1];
			end
		end
	end

	logic      v_sb;
	stcf_res_t res_sb;

	stcf_back #(
		.TEXEL_SIZE (TEXEL_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (dv_s[DIV_STEPS-1]),
		.side_in  (dside_s[DIV_STEPS-1]),
		.quot_u   (quot_u),
		.quot_v   (quot_v),
		.valid_sb (v_sb),
		.res_sb   (res_sb)
	);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= v_sb;
		end else if (v_sb) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (out_free) begin
			out_q <= res_sb;
		end else begin
			skid_q <= res_sb;
		end
	end

	assign out_valid = out_valid_q;
	assign tex_u = out_q.tex_u;
	assign tex_v = out_q.tex_v;
	assign fade_level = out_q.fade_level;
	assign in_square = out_q.in_square;
	assign divide_fault = out_q.divide_fault;
	assign mesh_done = out_q.mesh_done;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid_q)
		else $error("output buffer holds a result while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_stall |=> !skid_v_q)
		else $error("output buffer did not drain after a taken beat");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_valid_q && out_stall && v_sb))
		else $error("output buffer filled without a stalled result");

endmodule
